/* rtl/bscd_pkg.sv */
// Package for the byte-stuffed CRC-8 deframer: codes, constants and result types.
`default_nettype none

package bscd_pkg;

	// Default overflow limit on raw bytes per frame
	localparam int unsigned MAX_RAW_BYTES_DEF = 128;

	// Line codes
	localparam logic [7:0] MAGIC_BYTE  = 8'hFE;
	localparam logic [7:0] ESCAPE_BYTE = 8'hFD;
	localparam logic [7:0] ESCAPE_XOR  = 8'h20;

	// CRC-8/Maxim, reflected polynomial, zero initial value
	localparam logic [7:0] CRC_POLY = 8'h8C;
	localparam logic [7:0] CRC_INIT = 8'h00;

	// Result kinds
	typedef enum logic [1:0] {
		KIND_DATA  = 2'd0,
		KIND_END   = 2'd1,
		KIND_ABORT = 2'd2
	} kind_t;

	// One result item
	typedef struct packed {
		kind_t      kind;
		logic [7:0] data_byte;
		logic       crc_ok;
		logic [7:0] frame_length;
	} result_t;

	// What the core decides for the byte at its input
	typedef struct packed {
		logic    has_result;
		result_t result;
	} step_t;

endpackage

`default_nettype wire

/* rtl/bscd_if.sv */
// Valid/ready stream interfaces for raw line bytes and deframer results.
`default_nettype none

interface bscd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface bscd_result_if;
	logic                valid;
	logic                ready;
	bscd_pkg::kind_t     kind;
	logic [7:0]          data_byte;
	logic                crc_ok;
	logic [7:0]          frame_length;

	modport source (output valid, output kind, output data_byte, output crc_ok,
		output frame_length, input ready);
	modport sink   (input valid, input kind, input data_byte, input crc_ok,
		input frame_length, output ready);
endinterface

`default_nettype wire

/* rtl/bscd_crc8.sv */
// One-byte fold of the reflected CRC-8/Maxim, fully unrolled.
`default_nettype none

module bscd_crc8 (
	input  wire logic [7:0] crc,
	input  wire logic [7:0] data,
	output logic      [7:0] crc_next
);

	// Eight bit steps, LSB first
	always_comb begin
		logic [7:0] c;
		logic [7:0] d;
		c = crc;
		d = data;
		for (int k = 0; k < 8; k++) begin
			if (c[0] ^ d[0]) begin
				c = (c >> 1) ^ bscd_pkg::CRC_POLY;
			end else begin
				c = c >> 1;
			end
			d = d >> 1;
		end
		crc_next = c;
	end

endmodule

`default_nettype wire

/* rtl/bscd_core.sv */
// Frame state and per-byte decision: unescape, CRC, end of frame and overflow.
`default_nettype none

module bscd_core #(
	parameter int unsigned MAX_RAW_BYTES = bscd_pkg::MAX_RAW_BYTES_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [7:0]    rx_byte,
	input  wire logic          advance,
	output bscd_pkg::step_t    step
);

	logic       escape_pending_q;
	logic [7:0] raw_count_q;
	logic [7:0] running_crc_q;
	logic [7:0] decoded_count_q;

	logic       is_magic;
	logic       is_escape;
	logic [8:0] next_raw;
	logic       overflow;
	logic [7:0] unesc;
	logic [7:0] crc_next;

	assign is_magic  = (rx_byte == bscd_pkg::MAGIC_BYTE);
	assign is_escape = (rx_byte == bscd_pkg::ESCAPE_BYTE);
	assign next_raw  = {1'b0, raw_count_q} + 9'd1;
	assign overflow  = (next_raw >= 9'(MAX_RAW_BYTES));
	assign unesc     = escape_pending_q ? (rx_byte ^ bscd_pkg::ESCAPE_XOR) : rx_byte;

	bscd_crc8 u_crc8 (
		.crc      (running_crc_q),
		.data     (unesc),
		.crc_next (crc_next)
	);

	// Result decision for the byte at hand
	always_comb begin
		step.has_result          = 1'b0;
		step.result.kind         = bscd_pkg::KIND_DATA;
		step.result.data_byte    = 8'h00;
		step.result.crc_ok       = 1'b0;
		step.result.frame_length = 8'h00;
		if (is_magic) begin
			// close only a frame that holds raw bytes
			if (raw_count_q != 8'd0) begin
				step.has_result          = 1'b1;
				step.result.kind         = bscd_pkg::KIND_END;
				step.result.crc_ok       = (running_crc_q == 8'h00);
				step.result.frame_length = decoded_count_q;
			end
		end else if (overflow) begin
			step.has_result  = 1'b1;
			step.result.kind = bscd_pkg::KIND_ABORT;
		end else if (!is_escape) begin
			step.has_result       = 1'b1;
			step.result.data_byte = unesc;
		end
	end

	// Frame state, updated as the byte leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			escape_pending_q <= 1'b0;
			raw_count_q      <= 8'd0;
			running_crc_q    <= bscd_pkg::CRC_INIT;
			decoded_count_q  <= 8'd0;
		end else if (advance) begin
			if (is_magic || overflow) begin
				escape_pending_q <= 1'b0;
				raw_count_q      <= 8'd0;
				running_crc_q    <= bscd_pkg::CRC_INIT;
				decoded_count_q  <= 8'd0;
			end else begin
				raw_count_q <= next_raw[7:0];
				if (is_escape) begin
					escape_pending_q <= 1'b1;
				end else begin
					escape_pending_q <= 1'b0;
					running_crc_q    <= crc_next;
					decoded_count_q  <= decoded_count_q + 8'd1;
				end
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/byte_stuffed_crc8_deframer.sv */
// Top level of the byte-stuffed CRC-8/Maxim frame receiver.
`default_nettype none

// Raw line bytes enter on rx; one result per byte at most leaves on res:
// a data item per unescaped byte, an end item (crc_ok, frame_length) on 0xFE
// after a non-empty frame, or an abort item when MAX_RAW_BYTES raw bytes pile
// up. Throughput is one byte per clock while res takes the results; a byte
// lands in the input register, passes the combinational CRC fold and frame
// logic, and its result moves into the output register. Escape bytes and
// magic bytes on an empty frame produce no item. A waiting result does not
// block intake of the next byte unless that byte also has a result.

module byte_stuffed_crc8_deframer #(
	parameter int unsigned MAX_RAW_BYTES = bscd_pkg::MAX_RAW_BYTES_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	bscd_byte_if.sink      rx,
	bscd_result_if.source  res
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              out_valid_q;
	bscd_pkg::result_t out_res_q;
	bscd_pkg::step_t   step;
	logic              out_free;
	logic              advance;

	// Input stage moves on when its byte needs no slot or the slot is free
	assign out_free = !out_valid_q || res.ready;
	assign advance  = valid_s1 && (!step.has_result || out_free);
	assign rx.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.valid && rx.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	bscd_core #(
		.MAX_RAW_BYTES (MAX_RAW_BYTES)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx_byte (byte_s1),
		.advance (advance),
		.step    (step)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && step.has_result;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && step.has_result) begin
			out_res_q <= step.result;
		end
	end

	assign res.valid        = out_valid_q;
	assign res.kind         = out_res_q.kind;
	assign res.data_byte    = out_res_q.data_byte;
	assign res.crc_ok       = out_res_q.crc_ok;
	assign res.frame_length = out_res_q.frame_length;

`ifndef NO_ASSERTIONS
	// A held input byte stays put until it moves on
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(byte_s1)))
		else $error("input stage lost or changed a stalled byte");

	// A result is only written into a free output slot
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && step.has_result) |-> out_free)
		else $error("result written over a waiting item");

	// Frame length never reaches the overflow limit
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.kind == bscd_pkg::KIND_END) |->
		({1'b0, res.frame_length} < 9'(MAX_RAW_BYTES)))
		else $error("frame length beyond overflow limit");

	// Non-end items carry no CRC flag or length
	a_fields_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.kind != bscd_pkg::KIND_END) |->
		(!res.crc_ok && res.frame_length == 8'h00))
		else $error("end fields set on a data or abort item");
`endif

endmodule

`default_nettype wire
